/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the frame decoder; they compile to nothing under SYNTH
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property must hold at every clock edge outside reset
`define SCLFD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("sclfd assertion failed");
// condition must never be true outside reset
`define SCLFD_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("sclfd forbidden condition seen");
`else
`define SCLFD_ASSERT(lbl, clk, rst_n, prop)
`define SCLFD_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

/* hdl/sclfd_pkg.sv */
// ----------------------------------------------------------------------------
// sclfd_pkg
// Shared types and constants of the sync/command/length frame decoder
// ----------------------------------------------------------------------------
`default_nettype none

package sclfd_pkg;

	// framing constants
	localparam logic [7:0] SYNC_BYTE   = 8'hAA;
	localparam logic [3:0] NIBBLE_MASK = 4'hF;

	// descriptor queue between parser and drain
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// parser phases
	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_CMD  = 2'd1,
		PH_LEN  = 2'd2,
		PH_DATA = 2'd3
	} phase_t;

	// one completed frame, as handed to the drain side
	typedef struct packed {
		logic [7:0] cmd;
		logic [5:0] len;
		logic       bank;
	} frame_desc_t;

	// drain side hands a payload bank back to the parser
	typedef struct packed {
		logic valid;
		logic bank;
	} bank_release_t;

endpackage

`default_nettype wire

/* hdl/sclfd_ram.sv */
// ----------------------------------------------------------------------------
// sclfd_ram
// Simple dual-port RAM, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module sclfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* hdl/sclfd_front.sv */
// ----------------------------------------------------------------------------
// sclfd_front
// Byte parser: hunts sync, checks command, stores payload, queues frames
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sclfd_front
	import sclfd_pkg::*;
#(
	parameter int MAX_PAYLOAD = 63,
	parameter int IDX_W = 6
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [7:0]          rx_byte,
	input  wire logic                rx_valid,
	output logic                     rx_ready,
	output logic                     push,
	output frame_desc_t              push_desc,
	input  wire logic                queue_full,
	input  wire bank_release_t       release_bank,
	output logic                     wr_en,
	output logic [IDX_W:0]           wr_addr,
	output logic [7:0]               wr_data
);

	phase_t      phase_q, phase_d;
	logic [5:0]  fill_q, fill_d;
	logic [7:0]  cmd_q;
	logic [5:0]  len_q;
	logic        bank_q;
	logic [1:0]  busy_q, busy_d;
	logic        cmd_we, len_we, bank_flip;
	logic        accept;
	logic [3:0]  nib_x;
	logic [5:0]  fill_inc;

	// stall where a queue slot or a free bank is needed
	always_comb begin
		rx_ready = 1'b1;
		if (phase_q == PH_LEN && queue_full) begin
			rx_ready = 1'b0;
		end
		if (phase_q == PH_DATA && (queue_full || busy_q[bank_q])) begin
			rx_ready = 1'b0;
		end
	end

	assign accept   = rx_valid && rx_ready;
	assign nib_x    = rx_byte[7:4] ^ rx_byte[3:0];
	assign fill_inc = fill_q + 6'd1;
	assign wr_addr  = {bank_q, fill_q[IDX_W-1:0]};
	assign wr_data  = rx_byte;

	// next phase and side effects
	always_comb begin
		phase_d   = phase_q;
		fill_d    = fill_q;
		cmd_we    = 1'b0;
		len_we    = 1'b0;
		bank_flip = 1'b0;
		wr_en     = 1'b0;
		push      = 1'b0;
		push_desc = '{cmd: cmd_q, len: len_q, bank: bank_q};
		if (accept) begin
			unique case (phase_q)
				PH_HUNT: begin
					if (rx_byte == SYNC_BYTE) begin
						phase_d = PH_CMD;
					end
				end
				PH_CMD: begin
					if (nib_x == NIBBLE_MASK) begin
						cmd_we  = 1'b1;
						phase_d = PH_LEN;
					end else begin
						phase_d = PH_HUNT;
					end
				end
				PH_LEN: begin
					priority if (rx_byte == 8'd0) begin
						// empty frame goes out at once
						push          = 1'b1;
						push_desc.len = 6'd0;
						phase_d       = PH_HUNT;
					end else if (rx_byte <= 8'(MAX_PAYLOAD)) begin
						len_we  = 1'b1;
						fill_d  = 6'd0;
						phase_d = PH_DATA;
					end else if (rx_byte == SYNC_BYTE) begin
						phase_d = PH_CMD;
					end else begin
						phase_d = PH_HUNT;
					end
				end
				PH_DATA: begin
					if (fill_q >= len_q || {2'b00, fill_q} >= 8'(MAX_PAYLOAD)) begin
						phase_d = PH_HUNT;
						fill_d  = 6'd0;
					end else begin
						wr_en  = 1'b1;
						fill_d = fill_inc;
						if (fill_inc >= len_q) begin
							push      = 1'b1;
							bank_flip = 1'b1;
							fill_d    = 6'd0;
							phase_d   = PH_HUNT;
						end
					end
				end
				default: phase_d = PH_HUNT;
			endcase
		end
	end

	// bank ownership: set on queueing a frame with payload, cleared by the drain side
	always_comb begin
		busy_d = busy_q;
		if (release_bank.valid) begin
			busy_d[release_bank.bank] = 1'b0;
		end
		if (bank_flip) begin
			busy_d[bank_q] = 1'b1;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			fill_q  <= 6'd0;
			bank_q  <= 1'b0;
			busy_q  <= 2'b00;
		end else begin
			phase_q <= phase_d;
			fill_q  <= fill_d;
			busy_q  <= busy_d;
			if (bank_flip) begin
				bank_q <= ~bank_q;
			end
		end
	end

	// frame header
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q <= 8'd0;
			len_q <= 6'd0;
		end else begin
			if (cmd_we) begin
				cmd_q <= rx_byte;
			end
			if (len_we) begin
				len_q <= rx_byte[5:0];
			end
		end
	end

	`SCLFD_ASSERT(a_write_free_bank, clk, arst_n, wr_en |-> !busy_q[bank_q])
	`SCLFD_ASSERT(a_push_has_room, clk, arst_n, push |-> !queue_full)
	`SCLFD_ASSERT(a_write_in_frame, clk, arst_n, wr_en |-> (fill_q < len_q))

endmodule

`default_nettype wire

/* hdl/sclfd_fifo.sv */
// ----------------------------------------------------------------------------
// sclfd_fifo
// Short descriptor queue between the parser and the drain side
// ----------------------------------------------------------------------------
`default_nettype none

module sclfd_fifo
	import sclfd_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire frame_desc_t push_desc,
	input  wire logic  pop,
	output frame_desc_t head,
	output logic       empty,
	output logic       full
);

	frame_desc_t         entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]     count_q;

	assign head  = entry_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign full  = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* hdl/sclfd_back.sv */
// ----------------------------------------------------------------------------
// sclfd_back
// Drain side: walks the queued frame's payload bank and emits results
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sclfd_back
	import sclfd_pkg::*;
#(
	parameter int IDX_W = 6
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire frame_desc_t head,
	input  wire logic        queue_empty,
	output logic             pop,
	output bank_release_t    release_bank,
	output logic             rd_en,
	output logic [IDX_W:0]   rd_addr,
	input  wire logic [7:0]  rd_data,
	output logic             res_valid,
	input  wire logic        res_ready,
	output logic [7:0]       command,
	output logic [5:0]       payload_length,
	output logic [7:0]       data_byte,
	output logic             last
);

	logic [5:0] idx_q;
	logic       valid_s1;
	logic [7:0] cmd_s1;
	logic [5:0] len_s1;
	logic       last_s1;
	logic       empty_s1;
	logic       advance, issue, is_last, is_empty;

	// issue one result per cycle from the queue head while the result stage can advance
	assign advance  = !valid_s1 || res_ready;
	assign issue    = advance && !queue_empty;
	assign is_empty = (head.len == 6'd0);
	assign is_last  = is_empty || (idx_q == head.len - 6'd1);
	assign pop      = issue && is_last;
	assign rd_en    = issue && !is_empty;
	assign rd_addr  = {head.bank, idx_q[IDX_W-1:0]};

	// bank is free once its final read has been issued
	assign release_bank = '{valid: pop && !is_empty, bank: head.bank};

	// payload index within the current frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 6'd0;
		end else if (issue) begin
			idx_q <= is_last ? 6'd0 : idx_q + 6'd1;
		end
	end

	// result stage, lines up with the registered RAM read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			cmd_s1   <= head.cmd;
			len_s1   <= head.len;
			last_s1  <= is_last;
			empty_s1 <= is_empty;
		end
	end

	assign res_valid      = valid_s1;
	assign command        = cmd_s1;
	assign payload_length = len_s1;
	assign data_byte      = empty_s1 ? 8'd0 : rd_data;
	assign last           = last_s1;

	`SCLFD_ASSERT(a_pop_not_empty, clk, arst_n, pop |-> !queue_empty)
	`SCLFD_ASSERT(a_idx_in_frame, clk, arst_n, (issue && !is_empty) |-> (idx_q < head.len))
	`SCLFD_ASSERT(a_empty_is_last, clk, arst_n, (valid_s1 && empty_s1) |-> last_s1)

endmodule

`default_nettype wire

/* hdl/sync_cmd_length_frame_decoder_core.sv */
// ----------------------------------------------------------------------------
// sync_cmd_length_frame_decoder_core
// Frame decoder for a sync / command / length / payload byte stream
// ----------------------------------------------------------------------------
// Input channel rx_byte/rx_valid/rx_ready takes one received byte per
// transaction; output channel res_valid/res_ready gives one result per
// transaction (command, payload_length, data_byte, last).
// The parser takes a byte every cycle unless stalled. Payload goes into one of
// two RAM banks; the completed frame is queued (4 deep) and drained one result
// per cycle while the receiver is ready. A completed frame is first written
// into the queue, then read out through the registered RAM read alongside the
// result register; an empty frame is queued straight from its length byte.
// Throughput: one byte in and one result out per cycle when neither side
// stalls. A frame holds its payload bank until its final read is issued, so
// with both banks held the parser stalls on the next payload byte; a full
// queue stalls it on a length byte or a payload byte.
// A stalled receiver freezes the result register and, through the queue and
// the banks, eventually the input side; nothing is lost.
// Reset clears the parser to sync hunting and empties the queue; no RAM clear.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_cmd_length_frame_decoder_core
	import sclfd_pkg::*;
#(
	parameter int MAX_PAYLOAD = 63
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] rx_byte,
	input  wire logic       rx_valid,
	output logic            rx_ready,
	output logic [7:0]      command,
	output logic [5:0]      payload_length,
	output logic [7:0]      data_byte,
	output logic            last,
	output logic            res_valid,
	input  wire logic       res_ready
);

	// one bank holds at most 63 bytes, the reach of the 6-bit length
	localparam int BANK_DEPTH = (MAX_PAYLOAD < 63) ? MAX_PAYLOAD : 63;
	localparam int IDX_W      = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
	localparam int ADDR_W     = IDX_W + 1;
	localparam int RAM_DEPTH  = 2 ** ADDR_W;

	logic          push, pop, q_empty, q_full;
	frame_desc_t   push_desc, head;
	bank_release_t release_bank;
	logic          wr_en, rd_en;
	logic [IDX_W:0] wr_addr, rd_addr;
	logic [7:0]    wr_data, rd_data;

	sclfd_front #(
		.MAX_PAYLOAD(MAX_PAYLOAD),
		.IDX_W(IDX_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.rx_byte(rx_byte),
		.rx_valid(rx_valid),
		.rx_ready(rx_ready),
		.push(push),
		.push_desc(push_desc),
		.queue_full(q_full),
		.release_bank(release_bank),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	sclfd_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_desc(push_desc),
		.pop(pop),
		.head(head),
		.empty(q_empty),
		.full(q_full)
	);

	sclfd_ram #(
		.WIDTH(8),
		.DEPTH(RAM_DEPTH),
		.ADDR_W(ADDR_W)
	) u_ram (
		.clk(clk),
		.we(wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re(rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	sclfd_back #(
		.IDX_W(IDX_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.queue_empty(q_empty),
		.pop(pop),
		.release_bank(release_bank),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.command(command),
		.payload_length(payload_length),
		.data_byte(data_byte),
		.last(last)
	);

endmodule

`default_nettype wire

/* tb/sv/frame_result_checker.sv */
// ----------------------------------------------------------------------------
// frame_result_checker
// Watches both channels of the frame decoder, predicts the results of every
// accepted byte and compares each result transaction, field by field, with
// the oldest prediction still waiting
// ----------------------------------------------------------------------------
module frame_result_checker
	import sclfd_pkg::*;
#(
	parameter int MAX_LEN = 63
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] rx_byte,
	input  logic       rx_valid,
	input  logic       rx_ready,
	input  logic [7:0] command,
	input  logic [5:0] payload_length,
	input  logic [7:0] data_byte,
	input  logic       last,
	input  logic       res_valid,
	input  logic       res_ready,
	output int         fail_count,
	output int         results_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [7:0] cmd;
		logic [5:0] len;
		logic [7:0] data;
		logic       fin;
	} frame_result_t;

	// predictor state
	phase_t     phase;
	logic [5:0] fill;
	logic [7:0] held_cmd;
	logic [5:0] held_len;
	logic [7:0] payload_mem [0:MAX_LEN-1];

	frame_result_t frame_results [$];
	int            mismatches = 0;

	assign fail_count = mismatches;

	task automatic push_result(input logic [7:0] data, input logic fin);
		frame_result_t r;
		r.cmd  = held_cmd;
		r.len  = held_len;
		r.data = data;
		r.fin  = fin;
		frame_results.push_back(r);
	endtask

	// advance the frame parser by one byte, queue the results it completes
	task automatic decode_byte(input logic [7:0] b);
		logic [3:0] nib_x;
		int         k;
		nib_x = b[7:4] ^ b[3:0];
		case (phase)
			PH_HUNT: begin
				if (b == SYNC_BYTE)
					phase = PH_CMD;
			end
			PH_CMD: begin
				// high nibble must be the complement of the low one
				if (nib_x == NIBBLE_MASK) begin
					held_cmd = b;
					phase = PH_LEN;
				end else begin
					phase = PH_HUNT;
				end
			end
			PH_LEN: begin
				if (b == 8'd0) begin
					held_len = '0;
					push_result(8'd0, 1'b1);
					phase = PH_HUNT;
				end else if (b <= MAX_LEN) begin
					held_len = b[5:0];
					fill = '0;
					phase = PH_DATA;
				end else if (b == SYNC_BYTE) begin
					// sync byte here restarts the frame
					phase = PH_CMD;
				end else begin
					phase = PH_HUNT;
				end
			end
			default: begin
				if (fill >= held_len || fill >= MAX_LEN) begin
					phase = PH_HUNT;
					fill = '0;
				end else begin
					payload_mem[fill] = b;
					fill = fill + 6'd1;
					// last payload byte releases the whole run
					if (fill >= held_len) begin
						for (k = 0; k < int'(held_len) && k < MAX_LEN; k++)
							push_result(payload_mem[k], k == int'(held_len) - 1);
						phase = PH_HUNT;
						fill = '0;
					end
				end
			end
		endcase
	endtask

	task automatic check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name,
				want, got);
			mismatches++;
		end
	endtask

	// sample both channels at the clock edge
	always @(posedge clk or negedge arst_n) begin
		frame_result_t w;
		if (!arst_n) begin
			phase = PH_HUNT;
			fill = '0;
			held_cmd = '0;
			held_len = '0;
			frame_results.delete();
			results_owed <= 0;
		end else begin
			if (rx_valid && rx_ready)
				decode_byte(rx_byte);
			if (res_valid && res_ready) begin
				if (frame_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual cmd %0h len %0d data %0h last %0b",
						$realtime, command, payload_length, data_byte, last);
					mismatches++;
				end else begin
					w = frame_results.pop_front();
					check_field("command", w.cmd, command);
					check_field("payload_length", {2'b00, w.len}, {2'b00, payload_length});
					check_field("data_byte", w.data, data_byte);
					check_field("last", {7'd0, w.fin}, {7'd0, last});
				end
			end
			results_owed <= frame_results.size();
		end
	end

endmodule

/* tb/sv/tb_sync_cmd_length_frame_decoder_core.sv */
// ----------------------------------------------------------------------------
// tb_sync_cmd_length_frame_decoder_core
// Drives byte streams into the frame decoder: a directed run over empty,
// restarted, dropped and bad-command frames, then random framed traffic with
// noise, random idling on both channels and a drain pause; a side checker
// predicts and compares every result transaction
// ----------------------------------------------------------------------------
module tb_sync_cmd_length_frame_decoder_core
	import sclfd_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD   = 10;
	localparam int MAX_LEN      = 63;
	localparam int STALL_LIMIT  = 2000;
	localparam int RANDOM_BYTES = 106;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic [7:0] rx_byte = '0;
	logic       rx_valid = 1'b0;
	logic       res_ready = 1'b0;
	wire        rx_ready;
	wire  [7:0] command;
	wire  [5:0] payload_length;
	wire  [7:0] data_byte;
	wire        last;
	wire        res_valid;

	int   fail_count;
	int   results_owed;
	int   stall_cycles = 0;
	int   bytes_sent = 0;
	logic quiet = 1'b0;

	sync_cmd_length_frame_decoder_core #(
		.MAX_PAYLOAD(MAX_LEN)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.rx_byte(rx_byte),
		.rx_valid(rx_valid),
		.rx_ready(rx_ready),
		.command(command),
		.payload_length(payload_length),
		.data_byte(data_byte),
		.last(last),
		.res_valid(res_valid),
		.res_ready(res_ready)
	);

	frame_result_checker #(
		.MAX_LEN(MAX_LEN)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.rx_byte(rx_byte),
		.rx_valid(rx_valid),
		.rx_ready(rx_ready),
		.command(command),
		.payload_length(payload_length),
		.data_byte(data_byte),
		.last(last),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.fail_count(fail_count),
		.results_owed(results_owed)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// receiver backpressure
	always @(posedge clk) begin
		res_ready <= quiet || ($urandom_range(99) >= 16);
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((rx_valid && rx_ready) || (res_valid && res_ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	// present one byte, idling at random first, and hold it until taken
	task automatic send_byte(input logic [7:0] b);
		while (!quiet && $urandom_range(99) < 16) begin
			rx_valid <= 1'b0;
			@(posedge clk);
		end
		rx_byte <= b;
		rx_valid <= 1'b1;
		do @(posedge clk); while (!rx_ready);
		bytes_sent++;
	endtask

	// stop sending until every predicted result has come back
	task automatic wait_drained();
		rx_valid <= 1'b0;
		do @(posedge clk); while (results_owed != 0);
	endtask

	function automatic logic [7:0] good_cmd();
		logic [3:0] lo;
		lo = 4'($urandom_range(15));
		return {~lo, lo};
	endfunction

	task automatic send_frame(input logic [7:0] cmd, input int len);
		send_byte(SYNC_BYTE);
		send_byte(cmd);
		send_byte(len[7:0]);
		repeat (len)
			send_byte(($urandom_range(9) == 0) ? SYNC_BYTE : 8'($urandom_range(255)));
	endtask

	initial begin
		logic [7:0] directed_seq [0:23];
		logic [3:0] lo;
		int         start;
		int         sel;
		int         len;
		bit         big_done;
		bit         paused;

		big_done = 0;
		paused = 0;
		// junk, bad command, sync not restarting at command, empty frame,
		// sync restart at length, oversized lengths
		directed_seq = '{8'h00, 8'hFF,
			SYNC_BYTE, 8'h00,
			SYNC_BYTE, SYNC_BYTE, 8'h0F, 8'h00,
			SYNC_BYTE, 8'h0F, 8'h00,
			SYNC_BYTE, 8'hF0, SYNC_BYTE, 8'h5A, 8'h02, 8'h00, 8'hFF,
			SYNC_BYTE, 8'hC3, 8'h40,
			SYNC_BYTE, 8'h3C, 8'hFF};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_seq[i])
			send_byte(directed_seq[i]);
		wait_drained();

		// random traffic, mostly well-formed frames
		start = bytes_sent;
		while (bytes_sent - start < RANDOM_BYTES) begin
			quiet <= (bytes_sent - start >= 10) && (bytes_sent - start < 40);
			if (!paused && bytes_sent - start >= 70) begin
				paused = 1;
				wait_drained();
			end
			sel = $urandom_range(99);
			if (!big_done && bytes_sent - start >= 10) begin
				big_done = 1;
				send_frame(good_cmd(), MAX_LEN);
			end else if (sel < 72) begin
				if ($urandom_range(9) == 0)
					len = 0;
				else if ($urandom_range(9) == 0)
					len = $urandom_range(9, 24);
				else
					len = $urandom_range(1, 6);
				send_frame(good_cmd(), len);
			end else if (sel < 80) begin
				// command byte with nibbles not complementary
				lo = 4'($urandom_range(15));
				send_byte(SYNC_BYTE);
				send_byte({~lo ^ 4'($urandom_range(1, 15)), lo});
			end else if (sel < 86) begin
				send_byte(SYNC_BYTE);
				send_byte(good_cmd());
				send_byte(8'($urandom_range(MAX_LEN + 1, 255)));
			end else if (sel < 92) begin
				// sync in the length slot restarts the frame
				send_byte(SYNC_BYTE);
				send_byte(good_cmd());
				send_frame(good_cmd(), $urandom_range(0, 5));
			end else begin
				send_byte(8'($urandom_range(255)));
			end
		end

		quiet <= 1'b0;
		wait_drained();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* sim.f */
+incdir+hdl
hdl/sclfd_pkg.sv
hdl/sclfd_ram.sv
hdl/sclfd_front.sv
hdl/sclfd_fifo.sv
hdl/sclfd_back.sv
hdl/sync_cmd_length_frame_decoder_core.sv
tb/sv/frame_result_checker.sv
tb/sv/tb_sync_cmd_length_frame_decoder_core.sv
